// ===== rtl/aso_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// aso_pkg: shared types and constants of the scan averager
// Widths, register indexes and the word structures passed between modules.
// ----------------------------------------------------------------------------
package aso_pkg;

  // Number of scan slots holding a stored average.
  localparam int SLOTS        = 8;
  localparam int SLOT_W       = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  // Entries packed into the channel list register.
  localparam int LIST_ENTRIES = 8;
  localparam int MUX_W        = 5;
  localparam int MAX_LOG2     = 5;
  localparam int MAX_COUNT    = (SLOTS < LIST_ENTRIES) ? SLOTS : LIST_ENTRIES;

  localparam int SAMPLE_W     = 10;
  localparam int ACC_W        = 15;
  localparam int CNT_W        = 6;
  localparam int RSLOT_W      = 3;
  localparam int CCOUNT_W     = 4;
  localparam int LIST_W       = 40;
  localparam int LOG2_W       = 3;

  // Configuration port.
  localparam int CFG_IDX_W    = 2;
  localparam int CFG_DATA_W   = LIST_W;

  localparam logic [CFG_IDX_W-1:0] CFG_CHANNEL_COUNT   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_CHANNEL_LIST    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_OVERSAMPLE_LOG2 = 2'd2;

  // Input item kinds.
  localparam logic KIND_CONVERSION = 1'b0;
  localparam logic KIND_READ       = 1'b1;

  typedef logic [SLOT_W-1:0] slot_t;

  typedef struct packed {
    logic [CCOUNT_W-1:0] channel_count;
    logic [LIST_W-1:0]   channel_list;
    logic [LOG2_W-1:0]   oversample_log2;
  } cfg_t;

  typedef struct packed {
    logic                kind;
    logic [SAMPLE_W-1:0] sample;
    logic [RSLOT_W-1:0]  read_slot;
  } item_t;

  typedef struct packed {
    logic [SAMPLE_W-1:0] read_value;
    logic [MUX_W-1:0]    mux_code;
    logic                stored;
    logic [RSLOT_W-1:0]  stored_slot;
  } result_t;

endpackage

// ===== rtl/aso_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// aso_if: channel interfaces of the scan averager
// Input item channel, result channel and configuration write channel.
// ----------------------------------------------------------------------------
interface aso_item_if;
  logic                          valid;
  logic                          ready;
  logic                          kind;
  logic [aso_pkg::SAMPLE_W-1:0]  sample;
  logic [aso_pkg::RSLOT_W-1:0]   read_slot;

  modport source (output valid, kind, sample, read_slot, input ready);
  modport sink   (input valid, kind, sample, read_slot, output ready);
endinterface

interface aso_result_if;
  logic                          valid;
  logic                          ready;
  logic [aso_pkg::SAMPLE_W-1:0]  read_value;
  logic [aso_pkg::MUX_W-1:0]     mux_code;
  logic                          stored;
  logic [aso_pkg::RSLOT_W-1:0]   stored_slot;

  modport source (output valid, read_value, mux_code, stored, stored_slot, input ready);
  modport sink   (input valid, read_value, mux_code, stored, stored_slot, output ready);
endinterface

interface aso_cfg_if;
  logic                            valid;
  logic                            ready;
  logic [aso_pkg::CFG_IDX_W-1:0]   index;
  logic [aso_pkg::CFG_DATA_W-1:0]  data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// ===== rtl/aso_cfg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// aso_cfg: configuration registers
// Holds channel count, channel list and oversample exponent.
// ----------------------------------------------------------------------------
module aso_cfg (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             wr_en,
  input  logic [aso_pkg::CFG_IDX_W-1:0]    wr_index,
  input  logic [aso_pkg::CFG_DATA_W-1:0]   wr_data,
  output aso_pkg::cfg_t                    cfg
);

  // Register writes; an unknown index is ignored.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.channel_count   <= aso_pkg::CCOUNT_W'(1);
      cfg.channel_list    <= '0;
      cfg.oversample_log2 <= '0;
    end else if (wr_en) begin
      case (wr_index)
        aso_pkg::CFG_CHANNEL_COUNT: begin
          cfg.channel_count <= wr_data[aso_pkg::CCOUNT_W-1:0];
        end
        aso_pkg::CFG_CHANNEL_LIST: begin
          cfg.channel_list <= wr_data[aso_pkg::LIST_W-1:0];
        end
        aso_pkg::CFG_OVERSAMPLE_LOG2: begin
          cfg.oversample_log2 <= wr_data[aso_pkg::LOG2_W-1:0];
        end
        default: begin
        end
      endcase
    end
  end

endmodule

// ===== rtl/aso_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// aso_core: accumulate, store and scan logic
// Updates the accumulator, sample count, scan index and stored averages for
// each accepted conversion word and forms the result word of every accepted word.
// ----------------------------------------------------------------------------
module aso_core (
  input  logic              clk,
  input  logic              rst,
  input  aso_pkg::cfg_t     cfg,
  input  logic              accept,
  input  aso_pkg::item_t    item,
  output aso_pkg::result_t  result
);

  logic [aso_pkg::ACC_W-1:0]    accumulator;
  logic [aso_pkg::ACC_W-1:0]    accumulator_next;
  logic [aso_pkg::CNT_W-1:0]    sample_count;
  logic [aso_pkg::CNT_W-1:0]    sample_count_next;
  aso_pkg::slot_t               scan_index;
  aso_pkg::slot_t               scan_index_next;
  logic [aso_pkg::SAMPLE_W-1:0] averages [aso_pkg::SLOTS];

  logic [aso_pkg::LOG2_W-1:0]   shift;
  logic [aso_pkg::CCOUNT_W-1:0] count_eff;
  logic [aso_pkg::CNT_W-1:0]    threshold;
  logic                         do_store;
  logic [aso_pkg::SAMPLE_W-1:0] new_average;
  aso_pkg::slot_t               read_index;

  // Effective exponent and channel count after saturation.
  always_comb begin
    if (32'(cfg.oversample_log2) > aso_pkg::MAX_LOG2) begin
      shift = aso_pkg::LOG2_W'(aso_pkg::MAX_LOG2);
    end else begin
      shift = cfg.oversample_log2;
    end
    if (cfg.channel_count == '0) begin
      count_eff = aso_pkg::CCOUNT_W'(1);
    end else if (32'(cfg.channel_count) > aso_pkg::MAX_COUNT) begin
      count_eff = aso_pkg::CCOUNT_W'(aso_pkg::MAX_COUNT);
    end else begin
      count_eff = cfg.channel_count;
    end
    threshold = aso_pkg::CNT_W'(1) << shift;
  end

  // State update for a conversion word: add the sample, or store and advance.
  always_comb begin
    accumulator_next  = accumulator;
    sample_count_next = sample_count;
    scan_index_next   = scan_index;
    do_store          = 1'b0;
    new_average       = aso_pkg::SAMPLE_W'(accumulator >> shift);
    if (item.kind == aso_pkg::KIND_CONVERSION) begin
      if (sample_count < threshold) begin
        sample_count_next = sample_count + aso_pkg::CNT_W'(1);
        accumulator_next  = accumulator + aso_pkg::ACC_W'(item.sample);
      end else begin
        do_store          = 1'b1;
        accumulator_next  = '0;
        sample_count_next = '0;
        if (32'(scan_index) + 1 < 32'(count_eff)) begin
          scan_index_next = scan_index + aso_pkg::slot_t'(1);
        end else begin
          scan_index_next = '0;
        end
      end
    end
  end

  // Result word: read value, code of the slot now converting, store flag.
  always_comb begin
    read_index         = aso_pkg::slot_t'(item.read_slot);
    result.read_value  = '0;
    result.stored      = do_store;
    result.stored_slot = do_store ? aso_pkg::RSLOT_W'(scan_index) : '0;
    if (item.kind == aso_pkg::KIND_READ && 32'(item.read_slot) < aso_pkg::SLOTS) begin
      result.read_value = averages[read_index];
    end
    if (32'(scan_index_next) < aso_pkg::LIST_ENTRIES) begin
      result.mux_code =
        cfg.channel_list[aso_pkg::MUX_W * 32'(scan_index_next) +: aso_pkg::MUX_W];
    end else begin
      result.mux_code = '0;
    end
  end

  // Scan state registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      accumulator  <= '0;
      sample_count <= '0;
      scan_index   <= '0;
    end else if (accept) begin
      accumulator  <= accumulator_next;
      sample_count <= sample_count_next;
      scan_index   <= scan_index_next;
    end
  end

  // Stored averages, cleared at reset.
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < aso_pkg::SLOTS; i++) begin
        averages[i] <= '0;
      end
    end else if (accept && do_store) begin
      averages[scan_index] <= new_average;
    end
  end

endmodule

// ===== rtl/aso_out_stage.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// aso_out_stage: result register
// Holds one result word until the sink takes it; takes a new word in the
// same cycle as the held one leaves.
// ----------------------------------------------------------------------------
module aso_out_stage (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  aso_pkg::result_t  in_word,
  output logic              out_valid,
  input  logic              out_ready,
  output aso_pkg::result_t  out_word
);

  assign in_ready = !out_valid || out_ready;

  // Valid flag of the held word.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
  end

  // Payload register.
  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      out_word <= in_word;
    end
  end

endmodule

// ===== rtl/adc_scan_oversample_averager.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// adc_scan_oversample_averager: round-robin scan with oversampling average
//
//   channel  role    fields
//   item     sink    kind, sample, read_slot
//   result   source  read_value, mux_code, stored, stored_slot
//   cfg      sink    index, data (0 count, 1 list, 2 oversample exponent)
//
// One word per cycle is accepted; its result is registered and appears in the
// cycle after acceptance. Scan state is updated in the accepting cycle.
// Synchronous reset clears the scan state and all stored averages at once.
// A stalled result blocks new words only while the result register is full
// and not being emptied. Configuration writes are taken in any cycle.
// ----------------------------------------------------------------------------
module adc_scan_oversample_averager (
  input  logic          clk,
  input  logic          rst,
  aso_item_if.sink      item,
  aso_result_if.source  result,
  aso_cfg_if.sink       cfg
);

  aso_pkg::cfg_t     cfg_regs;
  aso_pkg::item_t    item_word;
  aso_pkg::result_t  core_word;
  aso_pkg::result_t  held_word;
  logic              stage_ready;
  logic              accept;

  assign cfg.ready  = 1'b1;
  assign item.ready = stage_ready;
  assign accept     = item.valid && stage_ready;

  assign item_word.kind      = item.kind;
  assign item_word.sample    = item.sample;
  assign item_word.read_slot = item.read_slot;

  // Configuration registers.
  aso_cfg u_cfg (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (cfg.valid),
    .wr_index (cfg.index),
    .wr_data  (cfg.data),
    .cfg      (cfg_regs)
  );

  // Accumulate and scan logic.
  aso_core u_core (
    .clk    (clk),
    .rst    (rst),
    .cfg    (cfg_regs),
    .accept (accept),
    .item   (item_word),
    .result (core_word)
  );

  // Result register.
  aso_out_stage u_out (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (item.valid),
    .in_ready  (stage_ready),
    .in_word   (core_word),
    .out_valid (result.valid),
    .out_ready (result.ready),
    .out_word  (held_word)
  );

  assign result.read_value  = held_word.read_value;
  assign result.mux_code    = held_word.mux_code;
  assign result.stored      = held_word.stored;
  assign result.stored_slot = held_word.stored_slot;

endmodule
